[sv/idq_pkg.sv]
`timescale 1ns / 1ps

package idq_pkg;

    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_ITEM_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int POS_W    = 10;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 11;

    // Depth of the command queue between the front and back parts.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_IDX_W = $clog2(CMD_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Where the back part takes the result item from.
    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_DATA,
        OUT_MEM
    } out_sel_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [ITEM_W-1:0] item_in;
    } in_beat_t;

    typedef struct packed {
        logic [ITEM_W-1:0]   item_out;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } out_beat_t;

    typedef struct packed {
        logic               mem_write;
        out_sel_t           out_sel;
        status_t            status;
        logic [OCC_W-1:0]   occupancy;
    } cmd_ctrl_t;

endpackage

[sv/idq_front.sv]
`timescale 1ns / 1ps

module idq_front #(
    parameter int CAPACITY   = idq_pkg::DEF_CAPACITY,
    parameter int ITEM_WIDTH = idq_pkg::DEF_ITEM_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  idq_pkg::in_beat_t             s_data,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output idq_pkg::cmd_ctrl_t            cmd_ctrl,
    output logic [$clog2(CAPACITY)-1:0]   cmd_addr,
    output logic [ITEM_WIDTH-1:0]         cmd_data
);
    import idq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [PTR_W:0]   CAP_SUM  = (PTR_W + 1)'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_m1;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] count_ext;
    logic             full;
    logic             empty;
    logic             accept;

    // Both operands are below CAPACITY, so one conditional subtract wraps the sum.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= CAP_SUM) begin
            sum = sum - CAP_SUM;
        end
        return sum[PTR_W-1:0];
    endfunction

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;

    assign full      = (count_reg == CAP_CNT);
    assign empty     = (count_reg == '0);
    assign count_m1  = count_reg - CNT_W'(1);
    assign pos_ext   = CMP_W'(s_data.position);
    assign count_ext = CMP_W'(count_reg);
    assign cmd_data  = ITEM_WIDTH'(s_data.item_in);

    always_comb begin
        front_next         = front_reg;
        count_next         = count_reg;
        cmd_addr           = '0;
        cmd_ctrl.mem_write = 1'b0;
        cmd_ctrl.out_sel   = OUT_ZERO;
        cmd_ctrl.status    = ST_DONE;
        case (op_t'(s_data.op))
            OP_PUSH_FRONT: begin
                if (full) begin
                    cmd_ctrl.status = ST_FULL;
                end else begin
                    front_next         = (front_reg == '0) ? LAST_IDX : front_reg - PTR_W'(1);
                    cmd_addr           = front_next;
                    cmd_ctrl.mem_write = 1'b1;
                    count_next         = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    cmd_ctrl.status = ST_FULL;
                end else begin
                    cmd_addr           = ring_add(front_reg, count_reg[PTR_W-1:0]);
                    cmd_ctrl.mem_write = 1'b1;
                    count_next         = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    cmd_ctrl.status = ST_MISS;
                end else begin
                    cmd_addr         = front_reg;
                    cmd_ctrl.out_sel = OUT_MEM;
                    front_next       = ring_add(front_reg, PTR_W'(1));
                    count_next       = count_m1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    cmd_ctrl.status = ST_MISS;
                end else begin
                    cmd_addr         = ring_add(front_reg, count_m1[PTR_W-1:0]);
                    cmd_ctrl.out_sel = OUT_MEM;
                    count_next       = count_m1;
                end
            end
            OP_READ, OP_WRITE: begin
                if (pos_ext >= count_ext) begin
                    cmd_ctrl.status = ST_MISS;
                end else begin
                    cmd_addr = ring_add(front_reg, pos_ext[PTR_W-1:0]);
                    if (op_t'(s_data.op) == OP_WRITE) begin
                        cmd_ctrl.mem_write = 1'b1;
                        cmd_ctrl.out_sel   = OUT_DATA;
                    end else begin
                        cmd_ctrl.out_sel = OUT_MEM;
                    end
                end
            end
            default: begin
            end
        endcase
        cmd_ctrl.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (accept) begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

[sv/idq_cmd_fifo.sv]
`timescale 1ns / 1ps

module idq_cmd_fifo #(
    parameter int CAPACITY   = idq_pkg::DEF_CAPACITY,
    parameter int ITEM_WIDTH = idq_pkg::DEF_ITEM_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  idq_pkg::cmd_ctrl_t            in_ctrl,
    input  logic [$clog2(CAPACITY)-1:0]   in_addr,
    input  logic [ITEM_WIDTH-1:0]         in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output idq_pkg::cmd_ctrl_t            out_ctrl,
    output logic [$clog2(CAPACITY)-1:0]   out_addr,
    output logic [ITEM_WIDTH-1:0]         out_data
);
    import idq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);

    cmd_ctrl_t             ctrl_mem [CMD_DEPTH];
    logic [PTR_W-1:0]      addr_mem [CMD_DEPTH];
    logic [ITEM_WIDTH-1:0] data_mem [CMD_DEPTH];

    logic [CMD_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_IDX_W:0]   fill_reg, fill_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = (fill_reg != (CMD_IDX_W + 1)'(CMD_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign out_ctrl = ctrl_mem[rd_ptr_reg];
    assign out_addr = addr_mem[rd_ptr_reg];
    assign out_data = data_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + CMD_IDX_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + CMD_IDX_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + (CMD_IDX_W + 1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (CMD_IDX_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ctrl_mem[wr_ptr_reg] <= in_ctrl;
            addr_mem[wr_ptr_reg] <= in_addr;
            data_mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[sv/idq_back.sv]
`timescale 1ns / 1ps

module idq_back #(
    parameter int CAPACITY   = idq_pkg::DEF_CAPACITY,
    parameter int ITEM_WIDTH = idq_pkg::DEF_ITEM_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  idq_pkg::cmd_ctrl_t            cmd_ctrl,
    input  logic [$clog2(CAPACITY)-1:0]   cmd_addr,
    input  logic [ITEM_WIDTH-1:0]         cmd_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output idq_pkg::out_beat_t            m_data
);
    import idq_pkg::*;

    logic [ITEM_WIDTH-1:0] ring_mem [CAPACITY];

    logic                  out_valid_reg;
    logic [ITEM_WIDTH-1:0] rd_data_reg;
    logic [ITEM_WIDTH-1:0] data_reg;
    out_sel_t              sel_reg;
    status_t               status_reg;
    logic [OCC_W-1:0]      occ_reg;
    logic                  advance;
    logic [ITEM_WIDTH-1:0] item_sel;

    // The result register takes a new command whenever it is empty or its beat leaves.
    assign cmd_ready = !out_valid_reg || m_ready;
    assign advance   = cmd_valid && cmd_ready;
    assign m_valid   = out_valid_reg;

    // Read data is taken before the write of the same command lands, which is
    // fine: a write reports the item it stores.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (cmd_ctrl.mem_write) begin
                ring_mem[cmd_addr] <= cmd_data;
            end
            rd_data_reg <= ring_mem[cmd_addr];
            data_reg    <= cmd_data;
            sel_reg     <= cmd_ctrl.out_sel;
            status_reg  <= cmd_ctrl.status;
            occ_reg     <= cmd_ctrl.occupancy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        case (sel_reg)
            OUT_DATA: item_sel = data_reg;
            OUT_MEM:  item_sel = rd_data_reg;
            default:  item_sel = '0;
        endcase
        m_data.item_out  = ITEM_W'(item_sel);
        m_data.status    = status_reg;
        m_data.occupancy = occ_reg;
    end

endmodule

[sv/indexed_double_ended_queue.sv]
`timescale 1ns / 1ps

// Double-ended queue of CAPACITY item words held in one ring memory, with
// push and pop at both ends and read or overwrite at a position counted from
// the front. Every accepted beat returns exactly one result beat, in order,
// carrying the removed, read or written item, a status and the item count
// afterward. The front part updates the head pointer and count in the cycle
// a beat is accepted, so one operation per clock is sustained while the
// command queue has room. The ring memory has a single port and a
// registered read; an accepted beat passes through the command queue into
// the result register. A four-entry command queue lets the input keep
// accepting while results are stalled. Entries are never cleared; after
// reset the queue is empty and needs no initialization time.
module indexed_double_ended_queue #(
    parameter int CAPACITY   = idq_pkg::DEF_CAPACITY,
    parameter int ITEM_WIDTH = idq_pkg::DEF_ITEM_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  idq_pkg::in_beat_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output idq_pkg::out_beat_t    m_data
);
    import idq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);

    logic                  fr_valid;
    logic                  fr_ready;
    cmd_ctrl_t             fr_ctrl;
    logic [PTR_W-1:0]      fr_addr;
    logic [ITEM_WIDTH-1:0] fr_data;

    logic                  bk_valid;
    logic                  bk_ready;
    cmd_ctrl_t             bk_ctrl;
    logic [PTR_W-1:0]      bk_addr;
    logic [ITEM_WIDTH-1:0] bk_data;

    idq_front #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd_ctrl  (fr_ctrl),
        .cmd_addr  (fr_addr),
        .cmd_data  (fr_data)
    );

    idq_cmd_fifo #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_ctrl   (fr_ctrl),
        .in_addr   (fr_addr),
        .in_data   (fr_data),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_ctrl  (bk_ctrl),
        .out_addr  (bk_addr),
        .out_data  (bk_data)
    );

    idq_back #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (bk_valid),
        .cmd_ready (bk_ready),
        .cmd_ctrl  (bk_ctrl),
        .cmd_addr  (bk_addr),
        .cmd_data  (bk_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[tb/idq_result_checker.sv]
`timescale 1ns / 1ps

module idq_result_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  idq_pkg::in_beat_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  idq_pkg::out_beat_t m_data,
    output int                 outstanding,
    output int                 fail_count
);
    import idq_pkg::*;

    logic [ITEM_W-1:0] ring [DEF_CAPACITY];
    logic [POS_W-1:0]  head;
    logic [OCC_W-1:0]  held;
    out_beat_t         pending_results[$];

    // The ring depth equals 2**POS_W, so pointer sums wrap on their own.
    function automatic out_beat_t apply_deque_op(in_beat_t b);
        out_beat_t        r;
        logic [POS_W-1:0] slot;
        r = '0;
        r.status = ST_DONE;
        case (b.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (held == OCC_W'(DEF_CAPACITY)) begin
                    r.status = ST_FULL;
                end else if (b.op == OP_PUSH_FRONT) begin
                    head = head - 1'b1;
                    ring[head] = b.item_in;
                    held = held + 1'b1;
                end else begin
                    ring[head + held[POS_W-1:0]] = b.item_in;
                    held = held + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (held == '0) begin
                    r.status = ST_MISS;
                end else if (b.op == OP_POP_FRONT) begin
                    r.item_out = ring[head];
                    head = head + 1'b1;
                    held = held - 1'b1;
                end else begin
                    r.item_out = ring[head + POS_W'(held - 1'b1)];
                    held = held - 1'b1;
                end
            end
            OP_READ, OP_WRITE: begin
                if (OCC_W'(b.position) >= held) begin
                    r.status = ST_MISS;
                end else begin
                    slot = head + b.position;
                    if (b.op == OP_WRITE) begin
                        ring[slot] = b.item_in;
                    end
                    r.item_out = ring[slot];
                end
            end
            default: begin
            end
        endcase
        r.occupancy = held;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        logic      bad;
        if (!aresetn) begin
            head = '0;
            held = '0;
            pending_results.delete();
            outstanding <= 0;
            fail_count <= 0;
        end else begin
            bad = 1'b0;
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_deque_op(s_data));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with none expected: item %h status %0d occ %0d",
                             $time, m_data.item_out, m_data.status, m_data.occupancy);
                    bad = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.item_out !== want.item_out) begin
                        $display("%0t: item_out expected %h actual %h",
                                 $time, want.item_out, m_data.item_out);
                        bad = 1'b1;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                        bad = 1'b1;
                    end
                    if (m_data.occupancy !== want.occupancy) begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occupancy, m_data.occupancy);
                        bad = 1'b1;
                    end
                end
            end
            if (bad) begin
                fail_count <= fail_count + 1;
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

[tb/indexed_double_ended_queue_tb.sv]
`timescale 1ns / 1ps

module indexed_double_ended_queue_tb;
    import idq_pkg::*;

    // Op codes the block treats as no operation.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int IDLE_PCT    = 28;
    localparam int STALL_LIMIT = 2000;
    localparam int QUIET_ITEMS = 300;
    localparam int FULL_ITEMS  = 40;
    localparam int MIXED_ITEMS = 200;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;
    int        outstanding;
    int        fail_count;
    logic      idle_enable = 1'b1;
    int        held = 0;
    int        stall_cycles = 0;

    always #4 aclk = ~aclk;

    indexed_double_ended_queue u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    idq_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always @(posedge aclk) begin
        m_ready <= !idle_enable || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] position,
                           input logic [ITEM_W-1:0] item);
        in_beat_t beat;
        beat.op = op;
        beat.position = position;
        beat.item_in = item;
        while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // Track the fill level only to steer the random mix.
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: if (held < DEF_CAPACITY) held++;
            OP_POP_FRONT, OP_POP_BACK:   if (held > 0) held--;
            default: begin
            end
        endcase
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Mostly positions inside the queue, some exactly one past the end.
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (held > 0 && r < 70) return POS_W'($urandom_range(held - 1));
        if (r < 85) return POS_W'(held);
        return POS_W'($urandom());
    endfunction

    task automatic send_access();
        if ($urandom_range(1)) send_op(OP_WRITE, pick_position(), $urandom());
        else send_op(OP_READ, pick_position(), $urandom());
    endtask

    task automatic send_push();
        if ($urandom_range(1)) send_op(OP_PUSH_FRONT, POS_W'($urandom()), $urandom());
        else send_op(OP_PUSH_BACK, POS_W'($urandom()), $urandom());
    endtask

    initial begin
        int n;
        int r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty queue: both pops, both accesses and the spare codes.
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_POP_BACK, 10'h3FF, 32'hFFFF_FFFF);
        send_op(OP_READ, '0, '0);
        send_op(OP_WRITE, 10'h3FF, 32'hFFFF_FFFF);
        send_op(OP_SPARE_LO, 10'h155, 32'h1234_5678);
        send_op(OP_SPARE_HI, 10'h2AA, 32'h8765_4321);
        // A front push from an empty ring wraps the head pointer.
        send_op(OP_PUSH_FRONT, '0, 32'hFFFF_FFFF);
        send_op(OP_PUSH_BACK, 10'h3FF, 32'h0000_0000);
        send_op(OP_PUSH_FRONT, '0, 32'hA5A5_A5A5);
        send_op(OP_PUSH_BACK, '0, 32'h5A5A_5A5A);
        send_op(OP_READ, 10'd0, '0);
        send_op(OP_READ, 10'd3, '0);
        send_op(OP_READ, 10'd4, '0);
        send_op(OP_READ, 10'h3FF, '0);
        send_op(OP_WRITE, 10'd1, 32'hDEAD_BEEF);
        send_op(OP_WRITE, 10'd3, 32'h0F0F_0F0F);
        send_op(OP_WRITE, 10'd4, 32'hFFFF_FFFF);
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        drain_results();

        // Fill to capacity, the first stretch with no idling on either side.
        idle_enable <= 1'b0;
        n = 0;
        while (held < DEF_CAPACITY) begin
            if (n == QUIET_ITEMS) idle_enable <= 1'b1;
            if ($urandom_range(99) < 85) send_push();
            else send_access();
            n++;
        end

        // Around full: dropped pushes, pops that reopen a slot, deep accesses.
        for (n = 0; n < FULL_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 40) send_push();
            else if (r < 60) send_op($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK,
                                     POS_W'($urandom()), $urandom());
            else send_access();
        end
        drain_results();

        for (n = 0; n < MIXED_ITEMS; n++) begin
            r = $urandom_range(7);
            if (r == OP_READ || r == OP_WRITE) send_access();
            else send_op(OP_W'(r), POS_W'($urandom()), $urandom());
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
sv/idq_pkg.sv
sv/idq_front.sv
sv/idq_cmd_fifo.sv
sv/idq_back.sv
sv/indexed_double_ended_queue.sv
tb/idq_result_checker.sv
tb/indexed_double_ended_queue_tb.sv
